// ===== src/dtsu_pkg.sv =====
`timescale 1ns / 1ps

package dtsu_pkg;

    localparam int TcwEntries = 1024;
    localparam int TcwAw      = $clog2(TcwEntries);

    // Request codes carried on the op field.
    typedef enum logic [2:0] {
        OP_WORD_DMA  = 3'd0,
        OP_BYTE_DMA  = 3'd1,
        OP_DMA_REFSD = 3'd2,
        OP_CPU_CHECK = 3'd3,
        OP_TCW_WR    = 3'd4,
        OP_TCW_RD    = 3'd5,
        OP_STAT_RD   = 3'd6,
        OP_STAT_CLR  = 3'd7
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MODE_BITS = 2'd0,
        CFG_BYTE_CHAN = 2'd1,
        CFG_MEM_USER  = 2'd2,
        CFG_PIO_USER  = 2'd3
    } t_cfg_idx;

    // CPU access kinds.
    localparam logic [1:0] KIND_LOAD = 2'd0;

    // Status bits; bit 15 is not stored and always reads as one.
    localparam logic [14:0] StExk   = 15'h0100;
    localparam logic [14:0] StInvop = 15'h0200;
    localparam logic [14:0] StPvio  = 15'h0400;
    localparam logic [14:0] StPd    = 15'h0800;
    localparam logic [14:0] StPer   = 15'h1000;
    localparam logic [14:0] StIntp  = 15'h2000;
    localparam logic [14:0] StExr   = 15'h4000;

    // Control word flags and fixed values.
    localparam int TcwIoBit   = 15;
    localparam int TcwVirtBit = 14;
    localparam logic [31:0] VirtBase  = 32'hE000_0000;
    localparam logic [3:0]  RegionChan = 4'd8;

    typedef struct packed {
        logic [7:0] mode_bits;
        logic [2:0] byte_chan;
        logic       mem_user;
        logic       pio_user;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [3:0]  channel;
        logic [23:0] offset;
        logic        user;
        logic        trans;
        logic        pio;
        logic [1:0]  kind;
        logic        csr;
        logic        byte_ref;
        logic        region;
        logic        ch_bad;
    } t_req;

    typedef struct packed {
        logic [31:0] sys_address;
        logic        pass_through;
        logic        region_used;
        logic        virtual_access;
        logic        access_ok;
        logic [31:0] read_value;
        logic        interrupt_line;
        logic        dma_reset_pulse;
    } t_res;

    // Error bit of a channel in the status register; channel 4 and
    // channels above 8 have none.
    function automatic logic [14:0] chan_bit(input logic [3:0] ch);
        logic [14:0] b;
        b = '0;
        case (ch)
            4'd0:    b = 15'h0001;
            4'd1:    b = 15'h0002;
            4'd2:    b = 15'h0004;
            4'd3:    b = 15'h0008;
            4'd5:    b = 15'h0010;
            4'd6:    b = 15'h0020;
            4'd7:    b = 15'h0040;
            4'd8:    b = 15'h0080;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/dtsu_tcw_ram.sv =====
`timescale 1ns / 1ps

module dtsu_tcw_ram
    import dtsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [TcwAw-1:0] i_addr,
    input  logic [15:0]      i_wdata,
    output logic [15:0]      o_rdata
);

    logic [15:0] r_mem [TcwEntries];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dtsu_front.sv =====
`timescale 1ns / 1ps

module dtsu_front
    import dtsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_op,
    input  logic [3:0]       i_channel,
    input  logic [23:0]      i_dma_offset,
    input  logic [TcwAw-1:0] i_tcw_index,
    input  logic             i_user_mode,
    input  logic             i_translated_mode,
    input  logic             i_target_pio,
    input  logic [1:0]       i_access_kind,
    input  logic             i_csr_target,
    input  logic             i_byte_refusal,
    input  t_cfg             i_cfg,
    output logic [TcwAw-1:0] o_ram_addr,
    output logic             o_ram_we,
    output logic             o_req_vld,
    output t_req             o_req
);

    t_op          op;
    logic         region_word;
    logic         region_byte;
    logic         ch_bad;
    logic [TcwAw-1:0] addr;
    logic         r_req_vld;
    t_req         r_req;

    assign op = t_op'(i_op);

    always_comb begin
        region_word = (i_channel == RegionChan) ||
                      i_cfg.mode_bits[3'd7 - i_channel[2:0]];
        region_byte = i_cfg.mode_bits[3'd7 - i_cfg.byte_chan];
        ch_bad      = i_channel inside {4'd4, [4'd9:4'd15]};
        case (op)
            OP_WORD_DMA: begin
                addr = region_word ? {1'b1, i_dma_offset[23:15]}
                                   : {i_channel, i_dma_offset[16:11]};
            end
            OP_BYTE_DMA: begin
                addr = {1'b0, i_cfg.byte_chan, 1'b0, i_dma_offset[15:11]};
            end
            default: begin
                addr = i_tcw_index;
            end
        endcase
    end

    assign o_ram_addr = addr;
    assign o_ram_we   = i_accept && (op == OP_TCW_WR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req.op       <= op;
            r_req.channel  <= i_channel;
            r_req.offset   <= i_dma_offset;
            r_req.user     <= i_user_mode;
            r_req.trans    <= i_translated_mode;
            r_req.pio      <= i_target_pio;
            r_req.kind     <= i_access_kind;
            r_req.csr      <= i_csr_target;
            r_req.byte_ref <= i_byte_refusal;
            r_req.region   <= (op == OP_BYTE_DMA) ? region_byte : region_word;
            r_req.ch_bad   <= ch_bad;
        end
    end

    assign o_req_vld = r_req_vld;
    assign o_req     = r_req;

endmodule

// ===== src/dtsu_back.sv =====
`timescale 1ns / 1ps

module dtsu_back
    import dtsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_vld,
    input  t_req        i_req,
    input  logic [15:0] i_rdata,
    input  t_cfg        i_cfg,
    output logic        o_done,
    output t_res        o_res
);

    logic [14:0] r_status;
    logic        r_int;
    logic        r_done;
    t_res        r_res;

    logic [14:0] n_status;
    logic        n_int;
    t_res        res;

    always_comb begin
        logic [14:0] fault_bit;
        logic        fault;
        logic        viol;
        n_status  = r_status;
        n_int     = r_int;
        res       = '0;
        res.access_ok = 1'b1;
        fault     = 1'b0;
        fault_bit = '0;
        viol      = 1'b0;

        case (i_req.op)
            OP_WORD_DMA: begin
                if (i_req.ch_bad) begin
                    res.access_ok = 1'b0;
                end else if (i_rdata[TcwIoBit]) begin
                    res.pass_through = 1'b1;
                    res.sys_address  = {8'd0, i_req.offset};
                end else if (i_req.region) begin
                    res.region_used = 1'b1;
                    res.sys_address = {8'd0, i_rdata[12:4], i_req.offset[14:0]};
                    if (i_rdata[TcwVirtBit]) begin
                        res.sys_address    = res.sys_address | VirtBase;
                        res.virtual_access = 1'b1;
                    end
                end else begin
                    res.sys_address = {8'd0, i_rdata[12:0], i_req.offset[10:0]};
                end
            end
            OP_BYTE_DMA: begin
                if (i_req.region) begin
                    fault     = 1'b1;
                    fault_bit = chan_bit({1'b0, i_cfg.byte_chan}) | StInvop;
                    res.dma_reset_pulse = 1'b1;
                    res.access_ok       = 1'b0;
                end else begin
                    res.sys_address  = {8'd0, i_rdata[12:0], i_req.offset[10:0]};
                    res.pass_through = i_rdata[TcwIoBit];
                end
            end
            OP_DMA_REFSD: begin
                fault     = 1'b1;
                fault_bit = (i_req.byte_ref ? chan_bit({1'b0, i_cfg.byte_chan})
                                            : chan_bit(i_req.channel)) | StExk;
                res.dma_reset_pulse = 1'b1;
                res.access_ok       = 1'b0;
            end
            OP_CPU_CHECK: begin
                if (i_req.pio && i_req.kind[1]) begin
                    n_status = n_status | StExr | StPer | StPd | StInvop;
                    res.access_ok = 1'b0;
                end else begin
                    viol = i_req.pio ? (i_req.user && (i_req.csr || !i_cfg.pio_user))
                                     : (i_req.user && !i_cfg.mem_user);
                    if (viol) begin
                        n_status = n_status | StPer | StPd | StPvio;
                        if ((i_req.kind == KIND_LOAD) || i_req.trans) begin
                            n_status = n_status | StExr;
                            res.access_ok = 1'b0;
                        end else if (!n_int) begin
                            n_status = n_status | StIntp;
                            n_int    = 1'b1;
                        end
                    end
                end
            end
            OP_TCW_WR: begin
                res.access_ok = 1'b1;
            end
            OP_TCW_RD: begin
                res.read_value = {i_rdata, i_rdata};
            end
            OP_STAT_RD: begin
                res.read_value = {16'd0, 1'b1, r_status};
            end
            OP_STAT_CLR: begin
                n_status = '0;
                n_int    = 1'b0;
            end
            default: begin
                res.access_ok = 1'b1;
            end
        endcase

        // A DMA error clears PER and PD, logs the error and raises the
        // interrupt if it is not already up.
        if (fault) begin
            n_status = (n_status & ~(StPer | StPd)) | fault_bit;
            if (!n_int) begin
                n_status = n_status | StIntp;
                n_int    = 1'b1;
            end
        end

        res.interrupt_line = n_int;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_int    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_req_vld;
            if (i_req_vld) begin
                r_status <= n_status;
                r_int    <= n_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_vld) begin
            r_res <= res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== src/dma_translation_and_status_unit.sv =====
// DMA translation and status unit. A request is taken whenever i_start is
// high (o_busy is always low, so one request may be issued every cycle),
// and its single result appears on the o_ result ports, marked by o_done
// for exactly one cycle; the receiver cannot stall, so it must capture the
// result in that cycle. The result passes through the translation control
// word RAM, whose read data is registered, and then the output register
// after the status and result logic. Configuration writes take effect at
// the clock edge at which i_cfg_we is high and should be issued only while
// no request is in flight.
`timescale 1ns / 1ps

module dma_translation_and_status_unit
    import dtsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_channel,
    input  logic [23:0] i_dma_offset,
    input  logic [9:0]  i_tcw_index,
    input  logic [15:0] i_tcw_value,
    input  logic        i_user_mode,
    input  logic        i_translated_mode,
    input  logic        i_target_pio,
    input  logic [1:0]  i_access_kind,
    input  logic        i_csr_target,
    input  logic        i_byte_refusal,
    output logic        o_done,
    output logic [31:0] o_sys_address,
    output logic        o_pass_through,
    output logic        o_region_used,
    output logic        o_virtual_access,
    output logic        o_access_ok,
    output logic [31:0] o_read_value,
    output logic        o_interrupt_line,
    output logic        o_dma_reset_pulse
);

    // Configuration registers, written through the plain write port.
    t_cfg r_cfg;

    logic             accept;
    logic [TcwAw-1:0] ram_addr;
    logic             ram_we;
    logic [15:0]      ram_rdata;
    logic             req_vld;
    t_req             req;
    t_res             res;

    // Every stage advances each cycle, so the unit never holds a request off.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE_BITS: r_cfg.mode_bits <= i_cfg_wdata;
                CFG_BYTE_CHAN: r_cfg.byte_chan <= i_cfg_wdata[2:0];
                CFG_MEM_USER:  r_cfg.mem_user  <= i_cfg_wdata[0];
                CFG_PIO_USER:  r_cfg.pio_user  <= i_cfg_wdata[0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // Stage one: pick the table entry for the request and register the
    // decoded request. A table write lands at the same edge, so a read by
    // the next request already sees the new value.
    dtsu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_op              (i_op),
        .i_channel         (i_channel),
        .i_dma_offset      (i_dma_offset),
        .i_tcw_index       (i_tcw_index),
        .i_user_mode       (i_user_mode),
        .i_translated_mode (i_translated_mode),
        .i_target_pio      (i_target_pio),
        .i_access_kind     (i_access_kind),
        .i_csr_target      (i_csr_target),
        .i_byte_refusal    (i_byte_refusal),
        .i_cfg             (r_cfg),
        .o_ram_addr        (ram_addr),
        .o_ram_we          (ram_we),
        .o_req_vld         (req_vld),
        .o_req             (req)
    );

    dtsu_tcw_ram u_tcw_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_tcw_value),
        .o_rdata (ram_rdata)
    );

    // Stage two: form the translated address, update the status register
    // and the interrupt, and register the result.
    dtsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (req_vld),
        .i_req     (req),
        .i_rdata   (ram_rdata),
        .i_cfg     (r_cfg),
        .o_done    (o_done),
        .o_res     (res)
    );

    assign o_sys_address     = res.sys_address;
    assign o_pass_through    = res.pass_through;
    assign o_region_used     = res.region_used;
    assign o_virtual_access  = res.virtual_access;
    assign o_access_ok       = res.access_ok;
    assign o_read_value      = res.read_value;
    assign o_interrupt_line  = res.interrupt_line;
    assign o_dma_reset_pulse = res.dma_reset_pulse;

`ifndef SYNTHESIS
    // Each accepted request produces its result strobe on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("result strobe missing two cycles after a request");

    // A DMA error always leaves the interrupt raised and rejects the access.
    a_fault_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dma_reset_pulse) |-> (o_interrupt_line && !o_access_ok))
        else $error("DMA error without interrupt or with access accepted");

    // A virtual access comes only from region mode and carries the high bits.
    a_virt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_virtual_access) |->
            (o_region_used && !o_pass_through && (o_sys_address[31:29] == 3'b111)))
        else $error("virtual access outside region translation");
`endif

endmodule

// ===== tb/sv/dtsu_tb_pkg.sv =====
`timescale 1ns / 1ps

package dtsu_tb_pkg;

    import dtsu_pkg::*;

    // Status register layout as this bench understands it.
    localparam logic [15:0] StsDmaExc   = 16'h0100;
    localparam logic [15:0] StsInvOp    = 16'h0200;
    localparam logic [15:0] StsProtViol = 16'h0400;
    localparam logic [15:0] StsPd       = 16'h0800;
    localparam logic [15:0] StsPer      = 16'h1000;
    localparam logic [15:0] StsIntPend  = 16'h2000;
    localparam logic [15:0] StsExcRep   = 16'h4000;
    localparam logic [15:0] StsReserved = 16'h8000;

    // Control word flag positions and the fixed address values.
    localparam int          TcwIoFlag      = 15;
    localparam int          TcwVirtFlag    = 14;
    localparam int          RegionBase     = 512;
    localparam logic [31:0] SysVirtualBase = 32'hE000_0000;

    // CPU access kinds.
    localparam logic [1:0] AccLoad   = 2'd0;
    localparam logic [1:0] AccStore  = 2'd1;
    localparam logic [1:0] AccModify = 2'd2;
    localparam logic [1:0] AccUnused = 2'd3;

    typedef struct packed {
        t_op         op;
        logic [3:0]  channel;
        logic [23:0] offset;
        logic [9:0]  tcw_index;
        logic [15:0] tcw_value;
        logic        user;
        logic        trans;
        logic        pio;
        logic [1:0]  kind;
        logic        csr;
        logic        byte_ref;
    } dtsu_request_t;

    class dtsu_result_checker;

        logic [15:0] tcw_mem [TcwEntries];
        logic [15:0] status_reg;
        bit          irq_line;
        logic [7:0]  mode_bits;
        logic [2:0]  byte_chan;
        bit          mem_user;
        bit          pio_user;

        t_res        pending_results [$];
        int unsigned op_count [8];
        int unsigned checked;
        int unsigned mismatches;

        function new();
            foreach (tcw_mem[i]) tcw_mem[i] = 16'h0000;
            status_reg = 16'h0000;
            irq_line   = 1'b0;
            mode_bits  = 8'h00;
            byte_chan  = 3'd0;
            mem_user   = 1'b0;
            pio_user   = 1'b0;
            checked    = 0;
            mismatches = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void set_config(input t_cfg_idx idx, input logic [7:0] value);
            case (idx)
                CFG_MODE_BITS: mode_bits = value;
                CFG_BYTE_CHAN: byte_chan = value[2:0];
                CFG_MEM_USER:  mem_user  = value[0];
                CFG_PIO_USER:  pio_user  = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function logic [15:0] error_bit_of(input logic [3:0] ch);
            if (ch < 4'd4)
                return 16'h0001 << ch;
            if (ch >= 4'd5 && ch <= 4'd8)
                return 16'h0001 << (ch - 4'd1);
            return 16'h0000;
        endfunction

        function bit region_selected(input logic [3:0] ch);
            return (ch == 4'd8) || mode_bits[3'd7 - ch[2:0]];
        endfunction

        // Table entry that a request reads, or -1 when it reads none.
        function int table_slot(input dtsu_request_t r);
            case (r.op)
                OP_WORD_DMA: begin
                    if (r.channel == 4'd4 || r.channel > 4'd8)
                        return -1;
                    if (region_selected(r.channel))
                        return RegionBase + int'(r.offset[23:15]);
                    return int'(r.channel) * 64 + int'(r.offset[16:11]);
                end
                OP_BYTE_DMA: begin
                    if (region_selected({1'b0, byte_chan}))
                        return -1;
                    return int'(byte_chan) * 64 + int'(r.offset[15:11]);
                end
                OP_TCW_RD: return int'(r.tcw_index);
                default:   return -1;
            endcase
        endfunction

        function void raise_irq();
            if (!irq_line) begin
                status_reg |= StsIntPend;
                irq_line = 1'b1;
            end
        endfunction

        function void log_channel_fault(input logic [3:0] ch, input logic [15:0] cause);
            status_reg &= ~(StsPer | StsPd);
            status_reg |= error_bit_of(ch) | cause;
            raise_irq();
        endfunction

        function t_res predict_outcome(input dtsu_request_t r);
            t_res        res;
            logic [15:0] w;
            int          slot;
            bit          viol;
            res = '0;
            res.access_ok = 1'b1;
            slot = table_slot(r);
            w = (slot >= 0) ? tcw_mem[slot] : 16'h0000;
            case (r.op)
                OP_WORD_DMA: begin
                    if (slot < 0) begin
                        res.access_ok = 1'b0;
                    end else if (w[TcwIoFlag]) begin
                        res.pass_through = 1'b1;
                        res.sys_address  = {8'h00, r.offset};
                    end else if (region_selected(r.channel)) begin
                        res.region_used = 1'b1;
                        res.sys_address = {8'h00, w[12:4], r.offset[14:0]};
                        if (w[TcwVirtFlag]) begin
                            res.sys_address   |= SysVirtualBase;
                            res.virtual_access = 1'b1;
                        end
                    end else begin
                        res.sys_address = {8'h00, w[12:0], r.offset[10:0]};
                    end
                end
                OP_BYTE_DMA: begin
                    if (slot < 0) begin
                        log_channel_fault({1'b0, byte_chan}, StsInvOp);
                        res.dma_reset_pulse = 1'b1;
                        res.access_ok       = 1'b0;
                    end else begin
                        res.sys_address  = {8'h00, w[12:0], r.offset[10:0]};
                        res.pass_through = w[TcwIoFlag];
                    end
                end
                OP_DMA_REFSD: begin
                    log_channel_fault(r.byte_ref ? {1'b0, byte_chan} : r.channel,
                                      StsDmaExc);
                    res.dma_reset_pulse = 1'b1;
                    res.access_ok       = 1'b0;
                end
                OP_CPU_CHECK: begin
                    if (r.pio && r.kind >= AccModify) begin
                        status_reg |= StsExcRep | StsPer | StsPd | StsInvOp;
                        res.access_ok = 1'b0;
                    end else begin
                        viol = r.user && (r.pio ? (r.csr || !pio_user) : !mem_user);
                        if (viol) begin
                            status_reg |= StsPer | StsPd | StsProtViol;
                            if (r.kind == AccLoad || r.trans) begin
                                status_reg |= StsExcRep;
                                res.access_ok = 1'b0;
                            end else begin
                                raise_irq();
                            end
                        end
                    end
                end
                OP_TCW_WR: tcw_mem[r.tcw_index] = r.tcw_value;
                OP_TCW_RD: res.read_value = {w, w};
                OP_STAT_RD: res.read_value = {16'h0000, status_reg | StsReserved};
                OP_STAT_CLR: begin
                    status_reg = 16'h0000;
                    irq_line   = 1'b0;
                end
                default: ;
            endcase
            res.interrupt_line = irq_line;
            return res;
        endfunction

        function void note_request(input dtsu_request_t r);
            pending_results.push_back(predict_outcome(r));
            op_count[r.op]++;
        endfunction

        function bit field_matches(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(input t_res got);
            t_res want;
            bit   ok;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            ok = field_matches("sys_address", want.sys_address, got.sys_address)
               & field_matches("pass_through", want.pass_through, got.pass_through)
               & field_matches("region_used", want.region_used, got.region_used)
               & field_matches("virtual_access", want.virtual_access, got.virtual_access)
               & field_matches("access_ok", want.access_ok, got.access_ok)
               & field_matches("read_value", want.read_value, got.read_value)
               & field_matches("interrupt_line", want.interrupt_line, got.interrupt_line)
               & field_matches("dma_reset_pulse", want.dma_reset_pulse,
                               got.dma_reset_pulse);
            if (!ok)
                mismatches++;
        endfunction

    endclass

endpackage

// ===== tb/sv/dma_translation_and_status_unit_tb.sv =====
`timescale 1ns / 1ps

module dma_translation_and_status_unit_tb;

    import dtsu_pkg::*;
    import dtsu_tb_pkg::*;

    // Random requests per register setting and the number of random settings.
    // The reset setting comes before them, exercised by the directed requests.
    // Table fills ahead of first reads add a few hundred more requests.
    localparam int PhaseItems   = 115;
    localparam int NumPhases    = 6;
    // A few spare cycles after the last result let anything unexpected show
    // up before the next step.
    localparam int SettleCycles = 6;
    // This is far beyond the length of the slowest correct run.
    localparam int CycleLimit   = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_wdata;
    logic [2:0]  i_op;
    logic [3:0]  i_channel;
    logic [23:0] i_dma_offset;
    logic [9:0]  i_tcw_index;
    logic [15:0] i_tcw_value;
    logic        i_user_mode;
    logic        i_translated_mode;
    logic        i_target_pio;
    logic [1:0]  i_access_kind;
    logic        i_csr_target;
    logic        i_byte_refusal;
    logic        o_done;
    logic [31:0] o_sys_address;
    logic        o_pass_through;
    logic        o_region_used;
    logic        o_virtual_access;
    logic        o_access_ok;
    logic [31:0] o_read_value;
    logic        o_interrupt_line;
    logic        o_dma_reset_pulse;

    dtsu_result_checker scoreboard = new();

    // Table entries that have been written; a request never reads any other.
    bit          tcw_loaded [TcwEntries];
    // When clear, requests go back to back with no idle cycles between them.
    bit          gaps_on;
    int unsigned cycle_count;
    int unsigned settings_used;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    dma_translation_and_status_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_channel         (i_channel),
        .i_dma_offset      (i_dma_offset),
        .i_tcw_index       (i_tcw_index),
        .i_tcw_value       (i_tcw_value),
        .i_user_mode       (i_user_mode),
        .i_translated_mode (i_translated_mode),
        .i_target_pio      (i_target_pio),
        .i_access_kind     (i_access_kind),
        .i_csr_target      (i_csr_target),
        .i_byte_refusal    (i_byte_refusal),
        .o_done            (o_done),
        .o_sys_address     (o_sys_address),
        .o_pass_through    (o_pass_through),
        .o_region_used     (o_region_used),
        .o_virtual_access  (o_virtual_access),
        .o_access_ok       (o_access_ok),
        .o_read_value      (o_read_value),
        .o_interrupt_line  (o_interrupt_line),
        .o_dma_reset_pulse (o_dma_reset_pulse)
    );

    // Port monitor. Inputs only change on the falling edge, so everything
    // read here at the rising edge is the value of the cycle that this edge
    // ends. The result is checked before the new request is noted, so a
    // stray result can never be matched against a request taken in the
    // same cycle.
    always @(posedge i_clk) begin : port_monitor
        t_res          seen;
        dtsu_request_t taken;
        if (i_rst_n) begin
            if (o_done) begin
                seen = '{sys_address:     o_sys_address,
                         pass_through:    o_pass_through,
                         region_used:     o_region_used,
                         virtual_access:  o_virtual_access,
                         access_ok:       o_access_ok,
                         read_value:      o_read_value,
                         interrupt_line:  o_interrupt_line,
                         dma_reset_pulse: o_dma_reset_pulse};
                scoreboard.check_result(seen);
            end
            if (i_start && !o_busy) begin
                taken.op        = t_op'(i_op);
                taken.channel   = i_channel;
                taken.offset    = i_dma_offset;
                taken.tcw_index = i_tcw_index;
                taken.tcw_value = i_tcw_value;
                taken.user      = i_user_mode;
                taken.trans     = i_translated_mode;
                taken.pio       = i_target_pio;
                taken.kind      = i_access_kind;
                taken.csr       = i_csr_target;
                taken.byte_ref  = i_byte_refusal;
                scoreboard.note_request(taken);
            end
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles with %0d results still expected",
                     cycle_count, scoreboard.outstanding());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request on the falling edge and hold it until the block
    // takes it. Start is left high; the next call or an idle cycle decides
    // what it does next, so it is only ever assigned once per edge.
    task automatic drive_request(input dtsu_request_t r);
        @(negedge i_clk);
        i_op              = r.op;
        i_channel         = r.channel;
        i_dma_offset      = r.offset;
        i_tcw_index       = r.tcw_index;
        i_tcw_value       = r.tcw_value;
        i_user_mode       = r.user;
        i_translated_mode = r.trans;
        i_target_pio      = r.pio;
        i_access_kind     = r.kind;
        i_csr_target      = r.csr;
        i_byte_refusal    = r.byte_ref;
        i_start           = 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
    endtask

    // While gaps are enabled, idle cycles are put in before a request at random, each with a 30 percent chance.
    task automatic random_gap();
        if (gaps_on)
            while ($urandom_range(0, 99) < 30)
                idle_cycles(1);
    endtask

    // Stop sending and wait for every outstanding result, plus a margin.
    // This is also the point where the register file may be rewritten.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_start = 1'b0;
        while (scoreboard.outstanding() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is idle. The checker's
    // copy of the setting changes in the same step as the block's.
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_start     = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        scoreboard.set_config(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] mode, input logic [2:0] bchan,
                                 input logic mu, input logic pu);
        write_reg(CFG_MODE_BITS, mode);
        write_reg(CFG_BYTE_CHAN, {5'd0, bchan});
        write_reg(CFG_MEM_USER, {7'd0, mu});
        write_reg(CFG_PIO_USER, {7'd0, pu});
        settings_used++;
    endtask

    // A request with every field random; the caller picks the operation.
    // Channels above 8 and the unused access kind show up now and then.
    function automatic dtsu_request_t random_request(input t_op op);
        dtsu_request_t r;
        r.op            = op;
        r.channel       = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 8))
                                                       : 4'($urandom_range(9, 15));
        r.offset        = 24'($urandom);
        r.tcw_index     = 10'($urandom);
        r.tcw_value     = 16'($urandom);
        // Keep most entries translating rather than passing through.
        r.tcw_value[TcwIoFlag] = ($urandom_range(0, 99) < 30);
        r.user          = 1'($urandom);
        r.trans         = 1'($urandom);
        r.pio           = 1'($urandom);
        r.kind          = ($urandom_range(0, 9) == 0) ? AccUnused
                                                      : 2'($urandom_range(0, 2));
        r.csr           = 1'($urandom);
        r.byte_ref      = 1'($urandom);
        return r;
    endfunction

    // Translations and CPU checks dominate; status clears are kept rare so
    // that the interrupt stays up across long stretches of requests.
    function automatic t_op pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 28) return OP_WORD_DMA;
        if (roll < 43) return OP_BYTE_DMA;
        if (roll < 50) return OP_DMA_REFSD;
        if (roll < 70) return OP_CPU_CHECK;
        if (roll < 82) return OP_TCW_WR;
        if (roll < 90) return OP_TCW_RD;
        if (roll < 96) return OP_STAT_RD;
        return OP_STAT_CLR;
    endfunction

    function automatic dtsu_request_t blank_request(input t_op op);
        dtsu_request_t r;
        r    = '0;
        r.op = op;
        return r;
    endfunction

    // Send a request. Any table entry that it would read but that holds
    // nothing yet is written first with random content, so every lookup is
    // a defined one while the translations still land all over the table.
    task automatic issue(input dtsu_request_t r);
        dtsu_request_t fill;
        int            slot;
        slot = scoreboard.table_slot(r);
        if (slot >= 0 && !tcw_loaded[slot]) begin
            fill           = random_request(OP_TCW_WR);
            fill.tcw_index = slot[9:0];
            tcw_loaded[slot] = 1'b1;
            random_gap();
            drive_request(fill);
        end
        if (r.op == OP_TCW_WR)
            tcw_loaded[r.tcw_index] = 1'b1;
        random_gap();
        drive_request(r);
    endtask

    initial begin
        dtsu_request_t r;
        logic [7:0]    mode;
        logic [2:0]    bchan;
        logic          mu;
        logic          pu;
        int            phase;
        int            n;

        i_rst_n           = 1'b0;
        i_start           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_MODE_BITS;
        i_cfg_wdata       = 8'h00;
        i_op              = OP_WORD_DMA;
        i_channel         = 4'd0;
        i_dma_offset      = 24'h000000;
        i_tcw_index       = 10'd0;
        i_tcw_value       = 16'h0000;
        i_user_mode       = 1'b0;
        i_translated_mode = 1'b0;
        i_target_pio      = 1'b0;
        i_access_kind     = AccLoad;
        i_csr_target      = 1'b0;
        i_byte_refusal    = 1'b0;
        gaps_on           = 1'b1;
        cycle_count       = 0;
        settings_used     = 1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests under the reset setting: channels 0 to 7 in page
        // mode, byte DMA on channel 0, user state locked out everywhere.

        // Status right after reset: only the reserved bit reads as one.
        issue(blank_request(OP_STAT_RD));

        // Page translation with the largest prefix and displacement.
        r = blank_request(OP_TCW_WR); r.tcw_index = 10'd0; r.tcw_value = 16'h1FFF; issue(r);
        r = blank_request(OP_WORD_DMA); r.offset = 24'h0007FF; issue(r);

        // I/O-channel entry: the offset goes out untranslated.
        r = blank_request(OP_TCW_WR); r.tcw_index = 10'd63; r.tcw_value = 16'h8000; issue(r);
        r = blank_request(OP_WORD_DMA); r.offset = 24'hFFFFFF; issue(r);

        // Channel 8 always uses the region half, here with the virtual flag.
        r = blank_request(OP_TCW_WR); r.tcw_index = 10'd512; r.tcw_value = 16'h5FF0; issue(r);
        r = blank_request(OP_WORD_DMA); r.channel = 4'd8; r.offset = 24'h007FFF; issue(r);

        // Last table entry, all ones: a region lookup that passes through.
        r = blank_request(OP_TCW_WR); r.tcw_index = 10'd1023; r.tcw_value = 16'hFFFF; issue(r);
        r = blank_request(OP_WORD_DMA); r.channel = 4'd8; r.offset = 24'hFFFFFF; issue(r);

        // Channel 4 and a channel above 8 are rejected without side effects.
        r = blank_request(OP_WORD_DMA); r.channel = 4'd4; r.offset = 24'h123456; issue(r);
        r = blank_request(OP_WORD_DMA); r.channel = 4'd15; issue(r);

        // Byte DMA through an I/O-channel entry keeps the translated address.
        r = blank_request(OP_TCW_WR); r.tcw_index = 10'd31; r.tcw_value = 16'h8123; issue(r);
        r = blank_request(OP_BYTE_DMA); r.offset = 24'h00F800; issue(r);
        r = blank_request(OP_BYTE_DMA); r.offset = 24'hFF0000; issue(r);

        // Refusals: a channel with an error bit, channel 4 with none, and
        // one from the byte path that names the byte controller's channel.
        r = blank_request(OP_DMA_REFSD); r.channel = 4'd3; issue(r);
        r = blank_request(OP_DMA_REFSD); r.channel = 4'd4; issue(r);
        r = blank_request(OP_DMA_REFSD); r.channel = 4'd9; r.byte_ref = 1'b1; issue(r);
        issue(blank_request(OP_STAT_RD));
        issue(blank_request(OP_STAT_CLR));

        // CPU checks: I/O modify, both with the modify code and the unused
        // code, a user load and a user store to memory, a user access to the
        // status register, and a supervisor load that passes.
        r = blank_request(OP_CPU_CHECK); r.pio = 1'b1; r.kind = AccModify; issue(r);
        r = blank_request(OP_CPU_CHECK); r.pio = 1'b1; r.kind = AccUnused; issue(r);
        r = blank_request(OP_CPU_CHECK); r.user = 1'b1; r.kind = AccLoad; issue(r);
        r = blank_request(OP_CPU_CHECK); r.user = 1'b1; r.kind = AccStore; issue(r);
        r = blank_request(OP_CPU_CHECK); r.user = 1'b1; r.pio = 1'b1; r.csr = 1'b1;
        r.kind = AccStore; r.trans = 1'b1; issue(r);
        r = blank_request(OP_CPU_CHECK); r.pio = 1'b1; r.kind = AccLoad; issue(r);

        r = blank_request(OP_TCW_RD); r.tcw_index = 10'd1023; issue(r);
        issue(blank_request(OP_STAT_RD));

        // Random requests under several settings, the extremes first. The
        // second setting runs back to back with no idle cycles at all.
        for (phase = 0; phase < NumPhases; phase++) begin
            wait_for_results();
            case (phase)
                0: begin mode = 8'hFF; bchan = 3'd7; mu = 1'b1; pu = 1'b1; end
                1: begin mode = 8'h00; bchan = 3'd0; mu = 1'b0; pu = 1'b0; end
                2: begin mode = 8'h80; bchan = 3'd3; mu = 1'b1; pu = 1'b0; end
                3: begin mode = 8'h01; bchan = 3'd7; mu = 1'b0; pu = 1'b1; end
                default: begin
                    mode  = 8'($urandom);
                    bchan = 3'($urandom_range(0, 7));
                    mu    = 1'($urandom);
                    pu    = 1'($urandom);
                end
            endcase
            apply_setting(mode, bchan, mu, pu);
            gaps_on = (phase != 1);
            for (n = 0; n < PhaseItems; n++) begin
                // Midway through one setting, hold off until all results
                // are back, then resume from a fully drained block.
                if (phase == 3 && n == PhaseItems / 2)
                    wait_for_results();
                issue(random_request(pick_op()));
            end
        end

        wait_for_results();

        $display("Checked %0d results over %0d settings: %0d word DMA, %0d byte DMA, %0d refusals",
                 scoreboard.checked, settings_used, scoreboard.op_count[OP_WORD_DMA],
                 scoreboard.op_count[OP_BYTE_DMA], scoreboard.op_count[OP_DMA_REFSD]);
        $display("CPU checks %0d, table writes %0d, table reads %0d, status reads %0d, clears %0d",
                 scoreboard.op_count[OP_CPU_CHECK], scoreboard.op_count[OP_TCW_WR],
                 scoreboard.op_count[OP_TCW_RD], scoreboard.op_count[OP_STAT_RD],
                 scoreboard.op_count[OP_STAT_CLR]);
        if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
